### hw/rtl/gepa_pkg.sv
`default_nettype none

package gepa_pkg;

    localparam int CMD_W  = 2;
    localparam int GRP_W  = 4;
    localparam int EIDX_W = 7;
    localparam int RES_W  = 6;
    localparam int ST_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_FIRST,
        CMD_NEXT
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_BAD_GROUP,
        ST_INACTIVE,
        ST_OUTSIDE,
        ST_END
    } t_status;

    typedef logic [GRP_W-1:0]  t_grp;
    typedef logic [EIDX_W-1:0] t_eidx;
    typedef logic [RES_W-1:0]  t_res;

    localparam t_eidx END_MARK = '1;

endpackage

`default_nettype wire

### hw/rtl/grouped_entry_pool_allocator.sv
// A result word is registered in the output register when its command word executes in stage one.
// Throughput: one command word per cycle while the output side does not stall.
// Each command reads the link, group and free-stack memories once at acceptance, with
// forwarding from the command ahead, and all updates are written when it executes in stage one.
// Reset (synchronous, active low) empties every group and refills the free stack at once;
// there is no clearing pass, and the first word can be accepted right after reset.
`default_nettype none

module grouped_entry_pool_allocator #(
    parameter int POOL_ENTRIES = 64,
    parameter int MAX_GROUP    = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [gepa_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [gepa_pkg::GRP_W-1:0]    i_group_id,
    input  wire logic [gepa_pkg::EIDX_W-1:0]   i_entry_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [gepa_pkg::ST_W-1:0]          o_status,
    output logic [gepa_pkg::RES_W-1:0]         o_result_index
);

    localparam int AW  = $clog2(POOL_ENTRIES);
    localparam int CW  = $clog2(POOL_ENTRIES + 1);
    localparam int NG  = MAX_GROUP + 1;
    localparam int GAW = (NG > 1) ? $clog2(NG) : 1;

    typedef logic [AW-1:0]  t_addr;
    typedef logic [CW-1:0]  t_cnt;
    typedef logic [GAW-1:0] t_gaddr;

    // Stage one: accepted command word and registered memory reads.
    logic                r_vld;
    gepa_pkg::t_cmd      r_cmd;
    gepa_pkg::t_grp      r_grp;
    gepa_pkg::t_eidx     r_idx;

    t_addr               m_next  [POOL_ENTRIES];
    t_addr               m_prev  [POOL_ENTRIES];
    gepa_pkg::t_grp      m_group [POOL_ENTRIES];
    t_addr               m_stack [POOL_ENTRIES];

    t_addr               r_next_mem;
    logic                r_next_fwd;
    t_addr               r_next_fdat;
    t_addr               r_prev_mem;
    logic                r_prev_fwd;
    t_addr               r_prev_fdat;
    gepa_pkg::t_grp      r_group_mem;
    logic                r_group_fwd;
    gepa_pkg::t_grp      r_group_fdat;
    t_addr               r_top_mem;
    logic                r_top_use_mem;
    t_addr               r_top_alt;

    // Pool state held in flip-flops.
    logic                r_fs_vld [POOL_ENTRIES];
    logic                r_active [POOL_ENTRIES];
    gepa_pkg::t_eidx     r_head   [NG];
    gepa_pkg::t_eidx     r_tail   [NG];
    t_cnt                r_count;

    // Output register.
    logic                r_out_vld;
    gepa_pkg::t_status   r_status;
    gepa_pkg::t_res      r_result;

    logic                accept;
    logic                exec;
    t_addr               rd_next;
    t_addr               rd_prev;
    gepa_pkg::t_grp      rd_group;
    t_addr               top;
    t_addr               ia;
    logic                idx_ok;
    logic                act;
    logic                grp_ok;
    gepa_pkg::t_grp      gsel;
    t_gaddr              gi;
    gepa_pkg::t_eidx     head_g;
    gepa_pkg::t_eidx     tail_g;
    gepa_pkg::t_eidx     p_link;
    gepa_pkg::t_eidx     n_link;

    gepa_pkg::t_status   n_status;
    gepa_pkg::t_res      n_result;
    t_cnt                n_count;
    logic                we_next;
    t_addr               wa_next;
    t_addr               wd_next;
    logic                we_prev;
    t_addr               wa_prev;
    t_addr               wd_prev;
    logic                we_group;
    t_addr               wa_group;
    gepa_pkg::t_grp      wd_group;
    logic                we_stack;
    t_addr               wa_stack;
    t_addr               wd_stack;
    logic                set_act;
    logic                clr_act;
    t_addr               act_addr;
    logic                we_head;
    gepa_pkg::t_eidx     wd_head;
    logic                we_tail;
    gepa_pkg::t_eidx     wd_tail;

    t_cnt                top_cnt;
    t_addr               top_addr;
    t_addr               rd_addr;
    logic                top_fwd;

    assign exec       = r_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_vld && !exec;
    assign accept     = i_in_valid && !o_in_stall;

    assign rd_next  = r_next_fwd  ? r_next_fdat  : r_next_mem;
    assign rd_prev  = r_prev_fwd  ? r_prev_fdat  : r_prev_mem;
    assign rd_group = r_group_fwd ? r_group_fdat : r_group_mem;
    assign top      = r_top_use_mem ? r_top_mem : r_top_alt;

    assign ia     = r_idx[AW-1:0];
    assign idx_ok = r_idx < gepa_pkg::t_eidx'(POOL_ENTRIES);
    assign act    = idx_ok && r_active[ia];
    assign grp_ok = r_grp <= gepa_pkg::t_grp'(MAX_GROUP);
    assign gsel   = (r_cmd inside {gepa_pkg::CMD_ALLOC, gepa_pkg::CMD_FIRST}) ? r_grp : rd_group;
    assign gi     = gsel[GAW-1:0];
    assign head_g = r_head[gi];
    assign tail_g = r_tail[gi];
    assign p_link = (head_g == r_idx) ? gepa_pkg::END_MARK : gepa_pkg::t_eidx'(rd_prev);
    assign n_link = (tail_g == r_idx) ? gepa_pkg::END_MARK : gepa_pkg::t_eidx'(rd_next);

    always_comb begin
        n_status = gepa_pkg::ST_OK;
        n_result = '0;
        n_count  = r_count;
        we_next  = 1'b0;
        wa_next  = '0;
        wd_next  = '0;
        we_prev  = 1'b0;
        wa_prev  = '0;
        wd_prev  = '0;
        we_group = 1'b0;
        wa_group = '0;
        wd_group = '0;
        we_stack = 1'b0;
        wa_stack = '0;
        wd_stack = '0;
        set_act  = 1'b0;
        clr_act  = 1'b0;
        act_addr = '0;
        we_head  = 1'b0;
        wd_head  = gepa_pkg::END_MARK;
        we_tail  = 1'b0;
        wd_tail  = gepa_pkg::END_MARK;
        if (exec) begin
            case (r_cmd)
                gepa_pkg::CMD_ALLOC: begin
                    if (r_count == '0) begin
                        n_status = gepa_pkg::ST_EMPTY;
                    end else if (!grp_ok) begin
                        n_status = gepa_pkg::ST_BAD_GROUP;
                    end else begin
                        n_count = r_count - t_cnt'(1);
                        if (tail_g != gepa_pkg::END_MARK) begin
                            we_next = 1'b1;
                            wa_next = tail_g[AW-1:0];
                            wd_next = top;
                        end else begin
                            we_head = 1'b1;
                            wd_head = gepa_pkg::t_eidx'(top);
                        end
                        we_prev  = 1'b1;
                        wa_prev  = top;
                        wd_prev  = tail_g[AW-1:0];
                        we_tail  = 1'b1;
                        wd_tail  = gepa_pkg::t_eidx'(top);
                        we_group = 1'b1;
                        wa_group = top;
                        wd_group = r_grp;
                        set_act  = 1'b1;
                        act_addr = top;
                        n_result = gepa_pkg::t_res'(top);
                    end
                end
                gepa_pkg::CMD_FREE: begin
                    if (!idx_ok) begin
                        n_status = gepa_pkg::ST_OUTSIDE;
                    end else if (!act) begin
                        n_status = gepa_pkg::ST_INACTIVE;
                    end else begin
                        if (p_link != gepa_pkg::END_MARK) begin
                            we_next = 1'b1;
                            wa_next = p_link[AW-1:0];
                            wd_next = n_link[AW-1:0];
                        end else begin
                            we_head = 1'b1;
                            wd_head = n_link;
                        end
                        if (n_link != gepa_pkg::END_MARK) begin
                            we_prev = 1'b1;
                            wa_prev = n_link[AW-1:0];
                            wd_prev = p_link[AW-1:0];
                        end else begin
                            we_tail = 1'b1;
                            wd_tail = p_link;
                        end
                        clr_act  = 1'b1;
                        act_addr = ia;
                        if (r_count < t_cnt'(POOL_ENTRIES)) begin
                            we_stack = 1'b1;
                            wa_stack = r_count[AW-1:0];
                            wd_stack = ia;
                            n_count  = r_count + t_cnt'(1);
                        end
                    end
                end
                gepa_pkg::CMD_FIRST: begin
                    if (!grp_ok) begin
                        n_status = gepa_pkg::ST_BAD_GROUP;
                    end else if (head_g == gepa_pkg::END_MARK) begin
                        n_status = gepa_pkg::ST_END;
                    end else begin
                        n_result = gepa_pkg::t_res'(head_g[AW-1:0]);
                    end
                end
                gepa_pkg::CMD_NEXT: begin
                    if (!idx_ok) begin
                        n_status = gepa_pkg::ST_OUTSIDE;
                    end else if (!act) begin
                        n_status = gepa_pkg::ST_INACTIVE;
                    end else if (tail_g == r_idx) begin
                        n_status = gepa_pkg::ST_END;
                    end else begin
                        n_result = gepa_pkg::t_res'(rd_next);
                    end
                end
                default: begin
                    n_status = gepa_pkg::ST_OK;
                end
            endcase
        end
    end

    // The stack top for the next word is read at the count left by the word ahead.
    assign top_cnt  = n_count - t_cnt'(1);
    assign top_addr = top_cnt[AW-1:0];
    assign top_fwd  = we_stack && (wa_stack == top_addr);
    assign rd_addr  = i_entry_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= t_cnt'(POOL_ENTRIES);
            for (int k = 0; k < POOL_ENTRIES; k++) begin
                r_active[k] <= 1'b0;
                r_fs_vld[k] <= 1'b0;
            end
            for (int k = 0; k < NG; k++) begin
                r_head[k] <= gepa_pkg::END_MARK;
                r_tail[k] <= gepa_pkg::END_MARK;
            end
        end else begin
            if (accept) begin
                r_vld <= 1'b1;
            end else if (exec) begin
                r_vld <= 1'b0;
            end
            if (exec) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_count <= n_count;
            if (set_act) begin
                r_active[act_addr] <= 1'b1;
            end else if (clr_act) begin
                r_active[act_addr] <= 1'b0;
            end
            if (we_stack) begin
                r_fs_vld[wa_stack] <= 1'b1;
            end
            if (we_head) begin
                r_head[gi] <= wd_head;
            end
            if (we_tail) begin
                r_tail[gi] <= wd_tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            m_next[wa_next] <= wd_next;
        end
        if (we_prev) begin
            m_prev[wa_prev] <= wd_prev;
        end
        if (we_group) begin
            m_group[wa_group] <= wd_group;
        end
        if (we_stack) begin
            m_stack[wa_stack] <= wd_stack;
        end
        if (accept) begin
            r_cmd         <= gepa_pkg::t_cmd'(i_cmd);
            r_grp         <= i_group_id;
            r_idx         <= i_entry_index;
            r_next_mem    <= m_next[rd_addr];
            r_next_fwd    <= we_next && (wa_next == rd_addr);
            r_next_fdat   <= wd_next;
            r_prev_mem    <= m_prev[rd_addr];
            r_prev_fwd    <= we_prev && (wa_prev == rd_addr);
            r_prev_fdat   <= wd_prev;
            r_group_mem   <= m_group[rd_addr];
            r_group_fwd   <= we_group && (wa_group == rd_addr);
            r_group_fdat  <= wd_group;
            r_top_mem     <= m_stack[top_addr];
            r_top_use_mem <= r_fs_vld[top_addr] && !top_fwd;
            r_top_alt     <= top_fwd ? wd_stack : top_addr;
        end
        if (exec) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_result_index = r_result;

endmodule

`default_nettype wire

### hw/rtl/gepa_checker.sv
`default_nettype none

module gepa_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [gepa_pkg::ST_W-1:0]     o_status,
    input wire logic [gepa_pkg::RES_W-1:0]    o_result_index
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_result_index))
        else $error("stalled result word changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != gepa_pkg::ST_OK) |-> o_result_index == '0)
        else $error("failed command returned a nonzero index");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind grouped_entry_pool_allocator gepa_checker u_gepa_checker (.*);

`default_nettype wire

### sim/pool_reply_checker.sv
module pool_reply_checker
    import gepa_pkg::*;
#(
    parameter int POOL_ENTRIES = 64,
    parameter int MAX_GROUP    = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [GRP_W-1:0]   i_group_id,
    input  wire logic [EIDX_W-1:0]  i_entry_index,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [ST_W-1:0]    i_status,
    input  wire logic [RES_W-1:0]   i_result_index,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUPS = MAX_GROUP + 1;

    typedef struct packed {
        t_status status;
        t_res    index;
    } pool_reply_t;

    pool_reply_t pending_replies[$];

    t_res        free_stack [POOL_ENTRIES];
    int unsigned free_count;
    t_eidx       next_link  [POOL_ENTRIES];
    t_eidx       prev_link  [POOL_ENTRIES];
    t_eidx       group_head [GROUPS];
    t_eidx       group_tail [GROUPS];
    t_grp        entry_group[POOL_ENTRIES];
    logic        entry_active[POOL_ENTRIES];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic void pool_clear();
        for (int k = 0; k < POOL_ENTRIES; k++) begin
            free_stack[k]   = t_res'(k);
            next_link[k]    = END_MARK;
            prev_link[k]    = END_MARK;
            entry_group[k]  = '0;
            entry_active[k] = 1'b0;
        end
        for (int k = 0; k < GROUPS; k++) begin
            group_head[k] = END_MARK;
            group_tail[k] = END_MARK;
        end
        free_count = POOL_ENTRIES;
    endfunction

    function automatic pool_reply_t pool_apply(input t_cmd cmd, input t_grp grp,
                                               input t_eidx idx);
        pool_reply_t reply;
        t_eidx       e;
        t_eidx       p;
        t_eidx       n;
        t_eidx       t;
        t_grp        g;
        reply.status = ST_OK;
        reply.index  = '0;
        case (cmd)
            CMD_ALLOC: begin
                if (free_count == 0) begin
                    reply.status = ST_EMPTY;
                end else if (grp > MAX_GROUP) begin
                    reply.status = ST_BAD_GROUP;
                end else begin
                    free_count = free_count - 1;
                    e = t_eidx'(free_stack[free_count]);
                    t = group_tail[grp];
                    prev_link[e] = t;
                    next_link[e] = END_MARK;
                    if (t < POOL_ENTRIES) begin
                        next_link[t] = e;
                    end else begin
                        group_head[grp] = e;
                    end
                    group_tail[grp] = e;
                    entry_group[e]  = grp;
                    entry_active[e] = 1'b1;
                    reply.index = t_res'(e);
                end
            end
            CMD_FREE: begin
                if (idx >= POOL_ENTRIES) begin
                    reply.status = ST_OUTSIDE;
                end else if (!entry_active[idx]) begin
                    reply.status = ST_INACTIVE;
                end else begin
                    g = entry_group[idx];
                    p = prev_link[idx];
                    n = next_link[idx];
                    if (p < POOL_ENTRIES) begin
                        next_link[p] = n;
                    end else begin
                        group_head[g] = n;
                    end
                    if (n < POOL_ENTRIES) begin
                        prev_link[n] = p;
                    end else begin
                        group_tail[g] = p;
                    end
                    next_link[idx]    = END_MARK;
                    prev_link[idx]    = END_MARK;
                    entry_active[idx] = 1'b0;
                    if (free_count < POOL_ENTRIES) begin
                        free_stack[free_count] = t_res'(idx);
                        free_count = free_count + 1;
                    end
                end
            end
            CMD_FIRST: begin
                if (grp > MAX_GROUP) begin
                    reply.status = ST_BAD_GROUP;
                end else if (group_head[grp] >= POOL_ENTRIES) begin
                    reply.status = ST_END;
                end else begin
                    reply.index = t_res'(group_head[grp]);
                end
            end
            default: begin
                if (idx >= POOL_ENTRIES) begin
                    reply.status = ST_OUTSIDE;
                end else if (!entry_active[idx]) begin
                    reply.status = ST_INACTIVE;
                end else if (next_link[idx] >= POOL_ENTRIES) begin
                    reply.status = ST_END;
                end else begin
                    reply.index = t_res'(next_link[idx]);
                end
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        pool_reply_t want;
        if (!i_rst_n) begin
            pool_clear();
            pending_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word with nothing expected: status %0d index %0d",
                        i_status, i_result_index));
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_result_index !== want.index) begin
                        report_mismatch($sformatf("result_index %0d, expected %0d",
                                                  i_result_index, want.index));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.insert(pending_replies.size(),
                                       pool_apply(t_cmd'(i_cmd), t_grp'(i_group_id),
                                                  t_eidx'(i_entry_index)));
            end
        end
        o_pending <= pending_replies.size();
    end

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gepa_pkg::*;

    localparam int POOL_ENTRIES = 64;
    localparam int MAX_GROUP    = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 9;
    localparam int PHASE_WORDS  = 195;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  cmd         = '0;
    logic [GRP_W-1:0]  group_id    = '0;
    logic [EIDX_W-1:0] entry_index = '0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [ST_W-1:0]   status;
    logic [RES_W-1:0]  result_index;

    int fail_count;
    int pending_count;
    int sent_words  = 0;
    int cycle_count = 0;
    int stall_run   = 0;
    bit calm        = 1'b0;

    int phase_alloc[PHASES] = '{85, 35, 5, 40, 85, 20, 5, 85, 35};
    int phase_free [PHASES] = '{5, 30, 80, 30, 5, 20, 80, 5, 30};
    int phase_first[PHASES] = '{5, 15, 5, 15, 5, 20, 5, 5, 15};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grouped_entry_pool_allocator #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .MAX_GROUP    (MAX_GROUP)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_group_id     (group_id),
        .i_entry_index  (entry_index),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_result_index (result_index)
    );

    pool_reply_checker #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .MAX_GROUP    (MAX_GROUP)
    ) u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_group_id     (group_id),
        .i_entry_index  (entry_index),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_result_index (result_index),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 35);
            stall_run <= pause_len();
        end
    end

    task automatic send_word(input t_cmd c, input t_grp g, input t_eidx x);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        group_id    <= g;
        entry_index <= x;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_words++;
    endtask

    task automatic send_random(input int w_alloc, input int w_free, input int w_first);
        int    r;
        t_cmd  c;
        t_grp  g;
        t_eidx x;
        r = $urandom_range(0, 99);
        if (r < w_alloc) begin
            c = CMD_ALLOC;
        end else if (r < w_alloc + w_free) begin
            c = CMD_FREE;
        end else if (r < w_alloc + w_free + w_first) begin
            c = CMD_FIRST;
        end else begin
            c = CMD_NEXT;
        end
        if ($urandom_range(0, 99) < 88) begin
            g = t_grp'($urandom_range(0, MAX_GROUP));
        end else begin
            g = t_grp'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 99) < 88) begin
            x = t_eidx'($urandom_range(0, POOL_ENTRIES - 1));
        end else begin
            x = t_eidx'($urandom_range(0, 127));
        end
        send_word(c, g, x);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(CMD_FIRST, 4'd0, 7'd0);
        send_word(CMD_NEXT,  4'd0, 7'd5);
        send_word(CMD_FREE,  4'd0, 7'd0);
        send_word(CMD_FREE,  4'd0, 7'd64);
        send_word(CMD_NEXT,  4'd15, 7'd127);
        send_word(CMD_ALLOC, 4'd15, 7'd0);
        send_word(CMD_FIRST, 4'd8, 7'd0);
        send_word(CMD_ALLOC, 4'd0, 7'd127);
        send_word(CMD_ALLOC, 4'd0, 7'd0);
        send_word(CMD_ALLOC, 4'd7, 7'd0);
        send_word(CMD_FIRST, 4'd0, 7'd0);
        send_word(CMD_NEXT,  4'd0, 7'd63);
        send_word(CMD_NEXT,  4'd0, 7'd62);
        send_word(CMD_FIRST, 4'd7, 7'd0);
        send_word(CMD_FREE,  4'd0, 7'd62);
        send_word(CMD_FREE,  4'd0, 7'd63);
        send_word(CMD_ALLOC, 4'd3, 7'd0);
        send_word(CMD_FREE,  4'd0, 7'd61);
        send_word(CMD_ALLOC, 4'd1, 7'd0);
        send_word(CMD_ALLOC, 4'd1, 7'd0);
        send_word(CMD_ALLOC, 4'd1, 7'd0);
        send_word(CMD_FREE,  4'd0, 7'd62);
        send_word(CMD_NEXT,  4'd0, 7'd61);
        send_word(CMD_FREE,  4'd0, 7'd63);
        send_word(CMD_FIRST, 4'd3, 7'd0);
        wait_for_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 3);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_random(phase_alloc[ph], phase_free[ph], phase_first[ph]);
            end
            if (ph == 2 || ph == 5) begin
                wait_for_results();
            end
        end
        calm = 1'b0;

        wait_for_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d command words: directed corner cases, then fill, drain and", sent_words);
        $display("list-walk phases with random command gaps and result stalls.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
